@@ hw/rtl/bounded_ordered_list_store_defines.svh @@
// Assertion macros shared by the bounded ordered list store RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BOUNDED_ORDERED_LIST_STORE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_STORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BOLST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bolst assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BOLST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bolst assertion failed");

`endif

@@ hw/rtl/bolst_pkg.sv @@
// Package for the bounded ordered list store: widths, codes and shared types.
// No dependencies; used by bolst_cell and bounded_ordered_list_store.
package bolst_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned OUT_W        = 40;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // Running minimum handed from cell to cell.
  typedef struct packed {
    logic                     has;
    logic signed [DATA_W-1:0] val;
  } pmin_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic occ;  // cell holds a live entry
    logic ins;  // load the input word into this cell
    logic rm;   // a remove is being applied this cycle
  } cell_ctl_t;

endpackage

@@ hw/rtl/bounded_ordered_list_store.sv @@
// Top level of the bounded ordered list store: a chain of bolst_cell cells,
// the sequencing control and the output register. Depends on bolst_pkg,
// bolst_cell and bounded_ordered_list_store_defines.svh.
//
// Usage:
//   The slave stream carries one command per word: s_axis_tuser selects
//   insert (append at the tail) or remove (drop the first equal entry), and
//   s_axis_tdata carries the signed 32-bit value. Every word produces one
//   result word on the master stream with the outcome, the element count,
//   the empty and full flags and the smallest held value (zero when empty).
//   An accepted word updates all cells in the same cycle: each cell compares
//   its entry with the value in parallel, and the first matching cell and the
//   cells after it take their right neighbor's entry. The smallest value then
//   ripples down the chain one cell per cycle through registered partial
//   minimums, and no new word is taken until the chain has settled and the
//   result has been loaded into the output register.
//   s_axis_tready is high only while no command is in flight. A finished
//   result sits in the output register until the receiver takes it; the
//   next command may be accepted meanwhile, and its result waits for the
//   register to free up. Reset empties the list and clears both streams.
module bounded_ordered_list_store #(
  parameter int unsigned CAPACITY = bolst_pkg::CAPACITY_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bolst_pkg::DATA_W-1:0]   s_axis_tdata,  // [31:0] value
  input  logic [0:0]                     s_axis_tuser,  // [0] command
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] ok, [5:1] count, [6] is_empty, [7] is_full, [39:8] smallest
  output logic [bolst_pkg::OUT_W-1:0]    m_axis_tdata
);
  import bolst_pkg::*;

  `include "bounded_ordered_list_store_defines.svh"

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e                   state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            scan_q, scan_d;
  logic                     ok_q, ok_d;
  logic                     m_valid_q, m_valid_d;
  logic [OUT_W-1:0]         m_data_q, m_data_d;

  logic                     in_acc;
  logic                     is_ins;
  logic                     is_rm;
  logic                     full_now;
  logic                     scan_done;
  logic                     out_free;
  logic                     load_out;
  logic signed [DATA_W-1:0] value;

  cell_ctl_t                ctl     [CAPACITY];
  logic signed [DATA_W-1:0] entry   [CAPACITY];
  logic                     hit     [CAPACITY];
  pmin_t                    pmin    [CAPACITY];

  // ---------------------------------------------------------------------
  // Input decode.
  // ---------------------------------------------------------------------
  assign value    = $signed(s_axis_tdata);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign is_ins   = in_acc && (cmd_e'(s_axis_tuser[0]) == CMD_INSERT);
  assign is_rm    = in_acc && (cmd_e'(s_axis_tuser[0]) == CMD_REMOVE);
  assign full_now = (count_q == CW'(CAPACITY));

  // ---------------------------------------------------------------------
  // Cell chain. Occupancy follows from the count; an insert lands in the
  // cell whose index equals the count, which never exists when full.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] nxt;
    logic                     hit_prev;
    pmin_t                    pmin_prev;

    assign ctl[i].occ = (CW'(i) < count_q);
    assign ctl[i].ins = is_ins && (count_q == CW'(i));
    assign ctl[i].rm  = is_rm;

    if (i == CAPACITY - 1) begin : g_last
      assign nxt = entry[i];
    end else begin : g_mid
      assign nxt = entry[i+1];
    end

    if (i == 0) begin : g_first
      assign hit_prev  = 1'b0;
      assign pmin_prev = '0;
    end else begin : g_rest
      assign hit_prev  = hit[i-1];
      assign pmin_prev = pmin[i-1];
    end

    bolst_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl[i]),
      .value_i      (value),
      .next_entry_i (nxt),
      .hit_i        (hit_prev),
      .pmin_i       (pmin_prev),
      .entry_o      (entry[i]),
      .hit_o        (hit[i]),
      .pmin_o       (pmin[i])
    );
  end

  // ---------------------------------------------------------------------
  // Count and outcome, captured at acceptance. The last cell's hit flag
  // says whether any occupied entry matched the value.
  // ---------------------------------------------------------------------
  always_comb begin
    count_d = count_q;
    ok_d    = ok_q;
    if (is_ins) begin
      ok_d = !full_now;
      if (!full_now) begin
        count_d = count_q + CW'(1);
      end
    end else if (is_rm) begin
      ok_d = hit[CAPACITY-1];
      if (hit[CAPACITY-1]) begin
        count_d = count_q - CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------
  assign scan_done = (scan_q == CW'(CAPACITY));
  assign out_free  = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs and the scan counter.
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    scan_d        = scan_q;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        scan_d        = '0;
      end
      ST_SCAN: begin
        if (scan_done) begin
          load_out = out_free;
        end else begin
          scan_d = scan_q + CW'(1);
        end
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (load_out) begin
      m_valid_d        = 1'b1;
      m_data_d[0]      = ok_q;
      m_data_d[5:1]    = COUNT_W'(count_q);
      m_data_d[6]      = (count_q == '0);
      m_data_d[7]      = (count_q == CW'(CAPACITY));
      m_data_d[39:8]   = (count_q == '0) ? '0 : pmin[CAPACITY-1].val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      scan_q    <= '0;
      ok_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      scan_q    <= scan_d;
      ok_q      <= ok_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `BOLST_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(CAPACITY))
  `BOLST_ASSERT_NXT(a_count_hold, clk_i, rst_ni, !in_acc, count_q == $past(count_q))
  `BOLST_ASSERT_NXT(a_insert_grows, clk_i, rst_ni, is_ins && !full_now, count_q == $past(count_q) + CW'(1))
  `BOLST_ASSERT_IMP(a_load_in_scan, clk_i, rst_ni, load_out, (state_q == ST_SCAN) && scan_done)

endmodule

@@ hw/rtl/bolst_cell.sv @@
// One cell of the list chain: holds one entry, matches it, and folds it into
// the running minimum passed down the chain. Depends on bolst_pkg.
module bolst_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bolst_pkg::cell_ctl_t              ctl_i,
  input  logic signed [bolst_pkg::DATA_W-1:0] value_i,
  input  logic signed [bolst_pkg::DATA_W-1:0] next_entry_i,
  input  logic                              hit_i,
  input  bolst_pkg::pmin_t                  pmin_i,
  output logic signed [bolst_pkg::DATA_W-1:0] entry_o,
  output logic                              hit_o,
  output bolst_pkg::pmin_t                  pmin_o
);
  import bolst_pkg::*;

  logic signed [DATA_W-1:0] entry_q, entry_d;
  pmin_t                    pmin_q, pmin_d;
  logic                     match;

  assign match = ctl_i.occ && (entry_q == value_i);
  // True from the first matching cell onward.
  assign hit_o = hit_i | match;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      entry_d = value_i;
    end else if (ctl_i.rm && hit_o) begin
      entry_d = next_entry_i;
    end
  end

  always_comb begin
    pmin_d = pmin_i;
    if (ctl_i.occ) begin
      pmin_d.has = 1'b1;
      if (!(pmin_i.has && (pmin_i.val < entry_q))) begin
        pmin_d.val = entry_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmin_q <= '0;
    end else begin
      pmin_q <= pmin_d;
    end
  end

  assign entry_o = entry_q;
  assign pmin_o  = pmin_q;

endmodule

@@ test/bounded_ordered_list_store_tb.sv @@
// Self-checking testbench for the bounded ordered list store.
// It needs bolst_pkg and bounded_ordered_list_store. A local model of the list
// predicts each result word, and the testbench drives both streams with random idling.
module bounded_ordered_list_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bolst_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int CLK_HALF    = 10;
  // Watchdog limit in ns. The run needs well under this limit, even under the
  // longest stalls.
  localparam int RUN_LIMIT   = 20_000_000;
  // Wait after the final drain before the verdict is printed.
  localparam int SETTLE_CYC  = CAPACITY + 6;
  localparam int RANDOM_WORDS = 826;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  // One result word, laid out as on m_axis_tdata. The first member is the MSB.
  typedef struct packed {
    logic signed [DATA_W-1:0] smallest;
    logic                     is_full;
    logic                     is_empty;
    logic [COUNT_W-1:0]       count;
    logic                     ok;
  } list_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [DATA_W-1:0]        s_axis_tdata;   // [31:0] value
  logic [0:0]               s_axis_tuser;   // [0] command
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OUT_W-1:0]         m_axis_tdata;   // [0] ok, [5:1] count, [6] is_empty,
                                            // [7] is_full, [39:8] smallest

  // These variables hold the state of the local list model.
  logic signed [DATA_W-1:0] list_entries [CAPACITY];
  int                       list_count;
  list_result_t             pending_results [$];

  int err_count;
  int words_sent;
  int burst_left;

  bounded_ordered_list_store #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Watchdog. A hang anywhere ends the run as a failure.
  initial begin
    #RUN_LIMIT;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    err_count++;
  endtask

  // This function applies one command to the local list and returns the result word
  // that the block must produce. An insert into a full list fails. A remove fails
  // on an empty list or when the value is absent. A remove takes out only the
  // lowest-position match.
  function automatic list_result_t predict_list_op(input cmd_e op,
                                                   input logic signed [DATA_W-1:0] v);
    list_result_t             r;
    int                       pos;
    logic signed [DATA_W-1:0] low;
    r    = '0;
    if (op == CMD_INSERT) begin
      if (list_count < CAPACITY) begin
        list_entries[list_count] = v;
        list_count++;
        r.ok = 1'b1;
      end
    end else begin
      pos = 0;
      while (pos < list_count && list_entries[pos] != v) pos++;
      if (pos < list_count) begin
        for (int i = pos + 1; i < list_count; i++) list_entries[i-1] = list_entries[i];
        list_count--;
        r.ok = 1'b1;
      end
    end
    // The smallest field is zero for an empty list. Only live positions are read.
    low = '0;
    if (list_count > 0) low = list_entries[0];
    for (int i = 1; i < list_count; i++) begin
      if (list_entries[i] < low) low = list_entries[i];
    end
    r.count    = COUNT_W'(list_count);
    r.is_empty = (list_count == 0);
    r.is_full  = (list_count == CAPACITY);
    r.smallest = low;
    return r;
  endfunction

  // This function returns a value from a mix of wide random words, a small pool that
  // produces duplicates, words near both extremes, and single-bit words.
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = $signed($urandom_range(0, 8)) - 4;
      7:          v = VAL_MIN + $urandom_range(0, 3);
      8:          v = VAL_MAX - $urandom_range(0, 3);
      default:    v = 32'sd1 <<< $urandom_range(0, DATA_W - 1);
    endcase
    return v;
  endfunction

  // This task sends one command word. The sender works in bursts. When a burst ends,
  // tvalid drops for a random gap, which is sometimes long. A word is accepted at
  // the edge where tready is seen high. The model advances at that edge.
  task automatic send_word(input cmd_e op, input logic signed [DATA_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_list_op(op, v));
    words_sent++;
  endtask

  // This task drops tvalid and waits until every outstanding result has arrived.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // This test covers a remove on the empty list, both value extremes, and a remove of
  // an absent value. It also removes the current minimum, so the smallest field must
  // move up to the next value.
  task automatic test_empty_and_extremes();
    send_word(CMD_REMOVE, '0);
    send_word(CMD_INSERT, VAL_MAX);
    send_word(CMD_INSERT, VAL_MIN);
    send_word(CMD_INSERT, '0);
    send_word(CMD_INSERT, -32'sd1);
    send_word(CMD_REMOVE, 32'sd123);
    send_word(CMD_REMOVE, VAL_MIN);
  endtask

  // This test inserts a duplicate value. A remove takes out only the first copy and
  // keeps the other one.
  task automatic test_duplicates();
    send_word(CMD_INSERT, 32'sd7);
    send_word(CMD_INSERT, 32'sd3);
    send_word(CMD_INSERT, 32'sd7);
    send_word(CMD_REMOVE, 32'sd7);
  endtask

  // This test fills the list to capacity, inserts once more (which must fail), and
  // removes the head entry. The sender then pauses until the list block has answered
  // every word.
  task automatic test_fill_and_overflow();
    while (list_count < CAPACITY) send_word(CMD_INSERT, pick_value());
    send_word(CMD_INSERT, 32'sd42);
    send_word(CMD_REMOVE, list_entries[0]);
    wait_drained();
  endtask

  // This test runs random traffic in phases, and each phase has its own mix of inserts.
  // A heavy-insert phase runs into the full list. A heavy-remove phase drains the
  // list to empty. Most removes name a value that the list holds. The rest name a
  // value that is probably absent.
  task automatic test_random_traffic();
    int   insert_pct;
    int   phase_len;
    int   phase_no;
    int   start_count;
    cmd_e op;
    logic signed [DATA_W-1:0] v;
    phase_no    = 0;
    start_count = words_sent;
    while (words_sent - start_count < RANDOM_WORDS) begin
      case ($urandom_range(0, 2))
        0:       insert_pct = 15;
        1:       insert_pct = 50;
        default: insert_pct = 85;
      endcase
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) begin
        op = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
        if (op == CMD_REMOVE && list_count > 0 && $urandom_range(0, 3) != 0)
          v = list_entries[$urandom_range(0, list_count - 1)];
        else
          v = pick_value();
        send_word(op, v);
      end
      phase_no++;
      if (phase_no == 6) wait_drained();
    end
  endtask

  // The receiver switches its stall mode at random. The modes are always
  // ready, random ready, a rotating pattern, and long stalls.
  initial begin
    int         stall_mode;
    int         cyc;
    logic [7:0] stall_pattern;
    m_axis_tready <= 1'b0;
    stall_mode    = 0;
    cyc           = 0;
    stall_pattern = 8'b1011_0010;
    forever begin
      @(posedge clk_i);
      if (cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
      cyc++;
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= $urandom_range(0, 1);
        2:       m_axis_tready <= stall_pattern[0];
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Every accepted result word is checked field by field against the oldest prediction.
  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with none pending", m_axis_tdata[DATA_W-1:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
        if (got.count !== want.count) report_mismatch("count", got.count, want.count);
        if (got.is_empty !== want.is_empty)
          report_mismatch("is_empty", got.is_empty, want.is_empty);
        if (got.is_full !== want.is_full)
          report_mismatch("is_full", got.is_full, want.is_full);
        if (got.smallest !== want.smallest)
          report_mismatch("smallest", got.smallest, want.smallest);
      end
    end
  end

  initial begin
    err_count     = 0;
    words_sent    = 0;
    burst_left    = 0;
    list_count    = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_INSERT;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_extremes();
    test_duplicates();
    test_fill_and_overflow();
    test_random_traffic();

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ bounded_ordered_list_store.f @@
+incdir+hw/rtl
hw/rtl/bolst_pkg.sv
hw/rtl/bolst_cell.sv
hw/rtl/bounded_ordered_list_store.sv
test/bounded_ordered_list_store_tb.sv
